[hdl/days_between_dates_defines.svh]
// ----------------------------------------------------------------------------
// days_between_dates assertion macros
// shared property shorthands for the checker of the date difference block
// ----------------------------------------------------------------------------
`ifndef DAYS_BETWEEN_DATES_DEFINES_SVH
`define DAYS_BETWEEN_DATES_DEFINES_SVH

// consequent must hold in the next cycle
`define DBD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("days_between_dates: next-cycle property failed");

// consequent must hold in the same cycle
`define DBD_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("days_between_dates: same-cycle property failed");

`endif

[hdl/dbd_pkg.sv]
// ----------------------------------------------------------------------------
// dbd_pkg
// types, constants and calendar helpers for the date difference block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbd_pkg;

   localparam int YEAR_BITS  = 14;
   localparam int DAY_BITS   = 5;
   localparam int MONTH_BITS = 4;
   localparam int DIST_BITS  = 22;
   localparam int DOY_BITS   = 9;
   // whole-year day count stays below 366 * 2**YEAR_BITS
   localparam int ACC_BITS   = YEAR_BITS + 9;
   localparam int SUM_BITS   = ACC_BITS + 1;
   localparam int WIDE_BITS  = (ACC_BITS > DIST_BITS) ? ACC_BITS : DIST_BITS;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   localparam logic [DOY_BITS-1:0] DAYS_COMMON = DOY_BITS'(365);
   localparam logic [DOY_BITS-1:0] DAYS_LEAP   = DOY_BITS'(366);

   // reciprocal for the divide-by-25 test, exact over the whole year range
   localparam int DIV25_SHIFT = YEAR_BITS + 5;
   localparam logic [YEAR_BITS:0] DIV25_MULT = (YEAR_BITS+1)'((2**DIV25_SHIFT + 24) / 25);

   typedef logic [YEAR_BITS-1:0]  year_type;
   typedef logic [DAY_BITS-1:0]   day_type;
   typedef logic [MONTH_BITS-1:0] month_type;
   typedef logic [DIST_BITS-1:0]  dist_type;
   typedef logic [DOY_BITS-1:0]   doy_type;
   typedef logic [ACC_BITS-1:0]   acc_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic year_done;
   } status_type;

   function automatic logic div25(input year_type y);
      logic [2*YEAR_BITS+5:0] prod;
      logic [YEAR_BITS-1:0]   q;
      logic [YEAR_BITS+4:0]   back;
      prod = (2*YEAR_BITS+6)'(y) * (2*YEAR_BITS+6)'(DIV25_MULT);
      q    = prod[DIV25_SHIFT +: YEAR_BITS];
      back = ((YEAR_BITS+5)'(q) << 4) + ((YEAR_BITS+5)'(q) << 3) + (YEAR_BITS+5)'(q);
      return back == (YEAR_BITS+5)'(y);
   endfunction

   // leap: divisible by 400, or by 4 and not by 100
   function automatic logic is_leap(input year_type y);
      logic d25;
      d25 = div25(y);
      return ((y[3:0] == 4'd0) && d25) || ((y[1:0] == 2'd0) && !d25);
   endfunction

   // days of the months before the given month, february at 28
   function automatic doy_type month_offset(input month_type m);
      doy_type r;
      case (m)
         4'd2:    r = DOY_BITS'(31);
         4'd3:    r = DOY_BITS'(59);
         4'd4:    r = DOY_BITS'(90);
         4'd5:    r = DOY_BITS'(120);
         4'd6:    r = DOY_BITS'(151);
         4'd7:    r = DOY_BITS'(181);
         4'd8:    r = DOY_BITS'(212);
         4'd9:    r = DOY_BITS'(243);
         4'd10:   r = DOY_BITS'(273);
         4'd11:   r = DOY_BITS'(304);
         4'd12:   r = DOY_BITS'(334);
         4'd13:   r = DOY_BITS'(365);
         4'd14:   r = DOY_BITS'(395);
         4'd15:   r = DOY_BITS'(425);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic doy_type day_of_year(input day_type d, input month_type m,
                                           input year_type y);
      doy_type r;
      r = month_offset(m) + DOY_BITS'(d);
      if ((m >= 4'd3) && is_leap(y)) begin
         r = r + DOY_BITS'(1);
      end
      return r;
   endfunction

endpackage

[hdl/dbd_control.sv]
// ----------------------------------------------------------------------------
// dbd_control
// sequencer for the date difference block: handshakes and year loop control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbd_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dbd_pkg::status_type status,
   output dbd_pkg::cmd_type    cmd
);
   import dbd_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PREP   = 2'd1;
   localparam logic [1:0] ST_LOOP   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (status.year_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/dbd_datapath.sv]
// ----------------------------------------------------------------------------
// dbd_datapath
// input capture, day-of-year terms, year accumulator and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbd_datapath (
   input  logic                 clock,
   input  dbd_pkg::day_type     req_day_a,
   input  dbd_pkg::month_type   req_month_a,
   input  dbd_pkg::year_type    req_year_a,
   input  dbd_pkg::day_type     req_day_b,
   input  dbd_pkg::month_type   req_month_b,
   input  dbd_pkg::year_type    req_year_b,
   input  dbd_pkg::cmd_type     cmd,
   output dbd_pkg::status_type  status,
   output dbd_pkg::dist_type    rsp_day_distance
);
   import dbd_pkg::*;

   day_type   day_a_ff, day_b_ff;
   month_type month_a_ff, month_b_ff;
   year_type  year_a_ff, year_b_ff;

   year_type  year_ff, year_in;
   year_type  year_hi_ff, year_hi_in;
   doy_type   doy_lo_ff, doy_lo_in;
   doy_type   doy_hi_ff, doy_hi_in;
   acc_type   acc_ff, acc_in;
   dist_type  dist_ff, dist_in;

   doy_type                 doy_a, doy_b;
   logic                    a_first;
   logic [SUM_BITS-1:0]     total;
   acc_type                 mag;
   logic [WIDE_BITS-1:0]    mag_wide;

   assign status.year_done = (year_ff == year_hi_ff);
   assign rsp_day_distance = dist_ff;

   assign doy_a   = day_of_year(day_a_ff, month_a_ff, year_a_ff);
   assign doy_b   = day_of_year(day_b_ff, month_b_ff, year_b_ff);
   assign a_first = (year_a_ff <= year_b_ff);

   // signed difference of the two ordinals, then magnitude and clamp
   assign total    = SUM_BITS'(acc_ff) + SUM_BITS'(doy_hi_ff) - SUM_BITS'(doy_lo_ff);
   assign mag      = total[SUM_BITS-1] ? ACC_BITS'(-total) : ACC_BITS'(total);
   assign mag_wide = WIDE_BITS'(mag);

   always_comb begin
      year_in    = year_ff;
      year_hi_in = year_hi_ff;
      doy_lo_in  = doy_lo_ff;
      doy_hi_in  = doy_hi_ff;
      acc_in     = acc_ff;
      dist_in    = dist_ff;
      if (cmd.prep) begin
         year_in    = a_first ? year_a_ff : year_b_ff;
         year_hi_in = a_first ? year_b_ff : year_a_ff;
         doy_lo_in  = a_first ? doy_a : doy_b;
         doy_hi_in  = a_first ? doy_b : doy_a;
         acc_in     = '0;
      end
      if (cmd.step) begin
         acc_in  = acc_ff + ACC_BITS'(is_leap(year_ff) ? DAYS_LEAP : DAYS_COMMON);
         year_in = year_ff + YEAR_BITS'(1);
      end
      if (cmd.finish) begin
         dist_in = (mag_wide > WIDE_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(mag_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_a_ff   <= req_day_a;
         month_a_ff <= req_month_a;
         year_a_ff  <= req_year_a;
         day_b_ff   <= req_day_b;
         month_b_ff <= req_month_b;
         year_b_ff  <= req_year_b;
      end
      year_ff    <= year_in;
      year_hi_ff <= year_hi_in;
      doy_lo_ff  <= doy_lo_in;
      doy_hi_ff  <= doy_hi_in;
      acc_ff     <= acc_in;
      dist_ff    <= dist_in;
   end

endmodule

[hdl/days_between_dates.sv]
// ----------------------------------------------------------------------------
// days_between_dates
// absolute day count between two gregorian dates
// ----------------------------------------------------------------------------
// usage:
//   req_ channel carries one transaction with two dates (day, month, year);
//   rsp_ channel returns one transaction with the day distance for each.
//   both channels use valid/ready; a transaction moves when both are high.
// timing:
//   after the request is taken, the block orders the dates and forms the
//   day-of-year terms, runs the year loop from the earlier year up to the
//   later one (one year added per cycle by a single accumulator), then
//   forms the clamped magnitude and loads the result.
//   a new request is taken the cycle after the result is loaded.
// reset:
//   synchronous, active high; returns to idle and drops rsp_valid.
// stall:
//   a held result stays in the output register; the next request may be
//   taken and worked on meanwhile, and waits at its last step until the
//   output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module days_between_dates (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dbd_pkg::day_type    req_day_a,
   input  dbd_pkg::month_type  req_month_a,
   input  dbd_pkg::year_type   req_year_a,
   input  dbd_pkg::day_type    req_day_b,
   input  dbd_pkg::month_type  req_month_b,
   input  dbd_pkg::year_type   req_year_b,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dbd_pkg::dist_type   rsp_day_distance
);
   import dbd_pkg::*;

   cmd_type    cmd;
   status_type status;

   dbd_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dbd_datapath u_datapath (
      .clock            (clock),
      .req_day_a        (req_day_a),
      .req_month_a      (req_month_a),
      .req_year_a       (req_year_a),
      .req_day_b        (req_day_b),
      .req_month_b      (req_month_b),
      .req_year_b       (req_year_b),
      .cmd              (cmd),
      .status           (status),
      .rsp_day_distance (rsp_day_distance)
   );

endmodule

[hdl/dbd_checker.sv]
// ----------------------------------------------------------------------------
// dbd_checker
// port-level properties of the date difference block, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "days_between_dates_defines.svh"

module dbd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input dbd_pkg::dist_type  rsp_day_distance
);
   import dbd_pkg::*;

   // held result keeps its value
   `DBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_day_distance))

   // block stays busy through the prep state and the first loop state after taking a request
   `DBD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready ##1 !req_ready)

   // a fresh result coincides with the return to idle
   `DBD_ASSERT_SAME(a_rsp_idle, clock, reset, $rose(rsp_valid), req_ready)

   // distance never exceeds the clamp value
   `DBD_ASSERT_SAME(a_rsp_range, clock, reset, rsp_valid, rsp_day_distance <= DIST_MAX)

endmodule

bind days_between_dates dbd_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_day_distance (rsp_day_distance)
);
